/* rtl/smf_pkg.sv */
// smf_pkg: shared types and constants for the sliding median filter
// no dependencies; imported by smf_cell, sliding_median_filter_top and tb_top
package smf_pkg;

	// width and reset value of the window length register
	localparam int CFG_WIDTH = 4;
	localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = 4'd3;

	// per-cycle control broadcast from the sequencer to every cell
	typedef struct packed {
		logic shift_en;  // take the neighbour's sample (new transaction)
		logic load_en;   // copy own sample into the rotating register, clear rank
		logic step_en;   // compare against the broadcast head, rotate ring
	} cell_ctrl_t;

endpackage

/* rtl/smf_cell.sv */
// smf_cell: one window position of the median filter chain
// holds a sample, a rotating copy and a rank counter; uses smf_pkg
module smf_cell import smf_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int LW           = 4,
	parameter int IDX          = 0
) (
	input  logic                           clk,
	input  cell_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] shift_in,
	input  logic signed [SAMPLE_WIDTH-1:0] rot_in,
	input  logic signed [SAMPLE_WIDTH-1:0] head,
	input  logic        [LW-1:0]           head_idx,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic signed [SAMPLE_WIDTH-1:0] circ_out,
	output logic        [LW-1:0]           rank
);

	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] circ_q;
	logic        [LW-1:0]           rank_q;
	logic                           head_below;

	// head sorts before this cell: smaller, or equal and newer position in the window
	assign head_below = (head < sample_q) ||
		((head == sample_q) && (head_idx < LW'(IDX)));

	// window sample, shifted along the chain on each new transaction
	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			sample_q <= shift_in;
		end
	end

	// rotating copy and rank count during evaluation
	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			circ_q <= sample_q;
			rank_q <= '0;
		end else if (ctrl.step_en) begin
			circ_q <= rot_in;
			if (head_below) begin
				rank_q <= rank_q + LW'(1);
			end
		end
	end

	assign sample_out = sample_q;
	assign circ_out   = circ_q;
	assign rank       = rank_q;

endmodule

/* rtl/sliding_median_filter_top.sv */
// sliding_median_filter_top: sliding window median over a chain of rank cells
// uses smf_pkg and smf_cell
// a window-completing sample gives its median via ST_LOAD, ST_EVAL and ST_SEL;
//   ST_EVAL ranks over len positions; len is the effective window length (1..MAX_WINDOW)
// input stalls until a window's median is registered, else one sample per cycle
// reset: window empty, window length 3, no result pending; stored samples are not cleared
module sliding_median_filter_top import smf_pkg::*; #(
	parameter int MAX_WINDOW   = 15,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic        [CFG_WIDTH-1:0]    cfg_wr_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           restart,
	output logic                           median_valid,
	input  logic                           median_stall,
	output logic signed [SAMPLE_WIDTH-1:0] median
);

	localparam int LW = $clog2(MAX_WINDOW + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EVAL,
		ST_SEL
	} state_t;

	state_t                         state_q;
	logic        [CFG_WIDTH-1:0]    window_length_q;
	logic        [LW-1:0]           len_q;
	logic        [LW-1:0]           target_q;
	logic        [LW-1:0]           fill_q;
	logic        [LW-1:0]           step_q;
	logic                           median_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] median_q;

	logic                           accept;
	logic                           sel_fire;
	logic        [LW-1:0]           len_eff;
	logic        [LW-1:0]           fill_base;
	logic        [LW-1:0]           fill_next;
	logic signed [SAMPLE_WIDTH-1:0] pick;
	cell_ctrl_t                     ctrl;

	logic signed [SAMPLE_WIDTH-1:0] sample_w [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] circ_w   [MAX_WINDOW];
	logic        [LW-1:0]           rank_w   [MAX_WINDOW];

	assign accept = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);

	// result moves into the output register once the previous one has left
	assign sel_fire = (state_q == ST_SEL) && (!median_valid_q || !median_stall);

	// clamp the configured length into 1..MAX_WINDOW
	always_comb begin
		if (window_length_q == '0) begin
			len_eff = LW'(1);
		end else if (int'(window_length_q) > MAX_WINDOW) begin
			len_eff = LW'(MAX_WINDOW);
		end else begin
			len_eff = LW'(window_length_q);
		end
	end

	// fill count after this transaction, saturating at the chain length
	assign fill_base = restart ? '0 : fill_q;
	assign fill_next = (fill_base == LW'(MAX_WINDOW)) ? fill_base : fill_base + LW'(1);

	// cell control
	always_comb begin
		ctrl.shift_en = accept;
		ctrl.load_en  = (state_q == ST_LOAD);
		ctrl.step_en  = (state_q == ST_EVAL);
	end

	// chain of cells: samples shift towards higher index, copies rotate towards cell 0
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		smf_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.LW           (LW),
			.IDX          (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.shift_in   ((i == 0) ? sample : sample_w[(i == 0) ? 0 : i - 1]),
			.rot_in     (circ_w[(i + 1) % MAX_WINDOW]),
			.head       (circ_w[0]),
			.head_idx   (step_q),
			.sample_out (sample_w[i]),
			.circ_out   (circ_w[i]),
			.rank       (rank_w[i])
		);
	end

	// pick the window cell whose rank equals len/2
	always_comb begin
		pick = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if ((LW'(i) < len_q) && (rank_w[i] == target_q)) begin
				pick = pick | sample_w[i];
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			window_length_q <= cfg_wr_data;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			step_q         <= '0;
			len_q          <= LW'(1);
			target_q       <= '0;
			median_valid_q <= 1'b0;
		end else begin
			if (sel_fire) begin
				median_valid_q <= 1'b1;
			end else if (!median_stall) begin
				median_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q   <= fill_next;
						len_q    <= len_eff;
						target_q <= len_eff >> 1;
						if (fill_next >= len_eff) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					step_q <= step_q + LW'(1);
					if (step_q == len_q - LW'(1)) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					// wait until the previous result has left the output register
					if (sel_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (sel_fire) begin
			median_q <= pick;
		end
	end

	assign median_valid = median_valid_q;
	assign median       = median_q;

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking bench for the sliding window median filter
// needs smf_pkg and sliding_median_filter_top; holds its own window model
// and compares every median it expects with what the block returns
`timescale 1ns / 1ps

module tb_top import smf_pkg::*;;

	localparam int MAX_WIN      = 15;
	localparam int SW           = 16;
	localparam int PHASE_ITEMS  = 175;
	localparam int NUM_PHASES   = 8;
	localparam int DRAIN_CYCLES = MAX_WIN + 20;
	localparam int STALL_LIMIT  = 5000;
	localparam int NUM_DIRECTED = 20;

	// how a directed row gets its expectation
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NONE,
		ROW_VALUE
	} row_kind_t;

	typedef struct packed {
		logic signed [SW-1:0] smp;
		logic                 rst;
		row_kind_t            kind;
		logic signed [SW-1:0] value;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_WIDTH-1:0]  cfg_wr_data;
	logic                  sample_valid;
	logic                  sample_stall;
	logic signed [SW-1:0]  sample;
	logic                  restart;
	logic                  median_valid;
	logic                  median_stall = 1'b0;
	logic signed [SW-1:0]  median;

	// window model state
	logic signed [SW-1:0]  win_store [MAX_WIN];
	int                    store_ptr;
	int                    fill_level;
	logic [CFG_WIDTH-1:0]  win_len;

	logic signed [SW-1:0]  expected_medians [$];
	stim_row_t             directed_rows [NUM_DIRECTED];
	row_kind_t             cur_kind;
	logic signed [SW-1:0]  cur_value;
	int                    send_idle_pct;
	int                    stall_pct = 0;
	int                    errors;
	int                    quiet_cycles;

	sliding_median_filter_top #(
		.MAX_WINDOW   (MAX_WIN),
		.SAMPLE_WIDTH (SW)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.restart      (restart),
		.median_valid (median_valid),
		.median_stall (median_stall),
		.median       (median)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// model of the window: takes one sample, says whether a median comes out
	function automatic void predict_median(input logic signed [SW-1:0] smp, input logic rst,
			output bit produced, output logic signed [SW-1:0] med);
		logic signed [SW-1:0] picked [MAX_WIN];
		logic signed [SW-1:0] key;
		int len;
		int pos;
		int i;
		int j;
		produced = 1'b0;
		med = '0;
		if (rst) begin
			fill_level = 0;
		end
		win_store[store_ptr] = smp;
		store_ptr = (store_ptr + 1) % MAX_WIN;
		if (fill_level < MAX_WIN) begin
			fill_level++;
		end
		// zero acts as one, anything past the store as the store size
		len = (win_len == '0) ? 1 : int'(win_len);
		if (len > MAX_WIN) begin
			len = MAX_WIN;
		end
		if (fill_level < len) begin
			return;
		end
		// most recent samples, newest first
		pos = store_ptr;
		for (i = 0; i < len; i++) begin
			pos = (pos + MAX_WIN - 1) % MAX_WIN;
			picked[i] = win_store[pos];
		end
		// ascending insertion sort
		for (i = 1; i < len; i++) begin
			key = picked[i];
			j = i;
			while (j > 0 && picked[j-1] > key) begin
				picked[j] = picked[j-1];
				j--;
			end
			picked[j] = key;
		end
		produced = 1'b1;
		med = picked[len/2];
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		median_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// both channels sampled at the rising edge, input side first
	always @(posedge clk) begin
		bit produced;
		bit moved;
		logic signed [SW-1:0] med;
		logic signed [SW-1:0] want;
		if (arst_n) begin
			moved = 1'b0;
			if (sample_valid && !sample_stall) begin
				moved = 1'b1;
				predict_median(sample, restart, produced, med);
				case (cur_kind)
					ROW_PREDICT: begin
						if (produced) expected_medians = {expected_medians, med};
					end
					ROW_VALUE: expected_medians = {expected_medians, cur_value};
					default: ;
				endcase
			end
			if (median_valid && !median_stall) begin
				moved = 1'b1;
				if (expected_medians.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected median transaction: %0d", median);
				end else begin
					want = expected_medians.pop_front();
					if (median !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("median mismatch: expected %0d, got %0d", want, median);
						end
					end
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// one input transaction, entered and left at a falling edge
	task automatic send_sample(input logic signed [SW-1:0] smp, input logic rst,
			input row_kind_t kind, input logic signed [SW-1:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= smp;
		restart      <= rst;
		cur_kind     = kind;
		cur_value    = value;
		do @(posedge clk); while (sample_stall);
		@(negedge clk);
	endtask

	// hold the sender off until every expected median is back
	task automatic drain_medians();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (expected_medians.size() != 0) @(negedge clk);
	endtask

	// register write while the block is idle
	task automatic write_length(input logic [CFG_WIDTH-1:0] len);
		drain_medians();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		win_len = len;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [SW-1:0] random_sample();
		case ($urandom_range(0, 3))
			0: return SW'($urandom_range(0, 15)) - SW'(8);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return SW'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		logic [CFG_WIDTH-1:0] phase_len;
		int p;
		int n;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		sample_valid  = 1'b0;
		sample        = '0;
		restart       = 1'b0;
		cur_kind      = ROW_PREDICT;
		cur_value     = '0;
		send_idle_pct = 0;
		errors        = 0;
		quiet_cycles  = 0;
		store_ptr     = 0;
		fill_level    = 0;
		win_len       = WINDOW_LENGTH_RESET;

		// directed rows at the reset length of three
		directed_rows = '{
			'{16'h7FFF, 1'b0, ROW_NONE,    16'h0000},
			'{16'h8000, 1'b0, ROW_NONE,    16'h0000},
			'{16'h0000, 1'b0, ROW_VALUE,   16'h0000},
			'{16'h7FFF, 1'b0, ROW_VALUE,   16'h0000},
			'{16'h7FFF, 1'b0, ROW_VALUE,   16'h7FFF},
			// restart empties the window
			'{16'h8000, 1'b1, ROW_NONE,    16'h0000},
			'{16'h8000, 1'b0, ROW_NONE,    16'h0000},
			'{16'h8000, 1'b0, ROW_VALUE,   16'h8000},
			'{16'h0001, 1'b0, ROW_VALUE,   16'h8000},
			'{16'hFFFF, 1'b0, ROW_VALUE,   16'hFFFF},
			// back-to-back restarts
			'{16'h04D2, 1'b1, ROW_NONE,    16'h0000},
			'{16'h0005, 1'b1, ROW_NONE,    16'h0000},
			'{16'hFFF9, 1'b0, ROW_NONE,    16'h0000},
			'{16'h0009, 1'b0, ROW_VALUE,   16'h0005},
			'{16'h5555, 1'b0, ROW_PREDICT, 16'h0000},
			'{16'hAAAA, 1'b0, ROW_PREDICT, 16'h0000},
			'{16'h7FFE, 1'b0, ROW_PREDICT, 16'h0000},
			'{16'hFFFE, 1'b0, ROW_PREDICT, 16'h0000},
			'{16'h0000, 1'b0, ROW_PREDICT, 16'h0000},
			'{16'h0000, 1'b0, ROW_PREDICT, 16'h0000}
		};

		// reset
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_sample(directed_rows[i].smp, directed_rows[i].rst,
				directed_rows[i].kind, directed_rows[i].value);
		end

		// random phases, each with its own length and idling pattern;
		// no restart at a phase boundary, so the new length works on held samples
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: phase_len = 4'd0;
				1: phase_len = 4'd15;
				2: phase_len = 4'd1;
				3: phase_len = 4'd8;
				4: phase_len = 4'd2;
				5: phase_len = 4'd15;
				default: phase_len = CFG_WIDTH'($urandom_range(0, 15));
			endcase
			write_length(phase_len);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 82; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 82; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) drain_medians();
				send_sample(random_sample(), ($urandom_range(0, 31) == 0),
					ROW_PREDICT, '0);
			end
		end

		// wait for the tail, then let any stray result show up
		drain_medians();
		repeat (DRAIN_CYCLES) @(negedge clk);
		errors += expected_medians.size();
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
